FILE: design/escaped_length_frame_deframer_top_defines.svh
// Assertion macros for the escaped length frame deframer.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef ESCAPED_LENGTH_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define ESCAPED_LENGTH_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Same-cycle implication.
`define ELDF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ELDF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/eldf_pkg.sv
// Package for the escaped length frame deframer: types, constants, kind decode.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package eldf_pkg;

  localparam logic [7:0] EscMark   = 8'h7D;
  localparam logic [7:0] EscXor    = 8'h20;
  localparam logic [7:0] StartMark = 8'h7E;
  localparam logic [7:0] TypeRx    = 8'h90;
  localparam logic [7:0] TypeIo    = 8'h92;
  localparam logic [7:0] TypeAt    = 8'h88;

  localparam logic [1:0] KindRx      = 2'd0;
  localparam logic [1:0] KindIo      = 2'd1;
  localparam logic [1:0] KindAt      = 2'd2;
  localparam logic [1:0] KindUnknown = 2'd3;

  // Queue between front and back.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  // Result queue in the back part.
  localparam int OutDepth = 2;
  localparam int OutPtrW  = $clog2(OutDepth);
  localparam int OutCntW  = $clog2(OutDepth + 1);

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LENH = 2'd1,
    PH_LENL = 2'd2,
    PH_BODY = 2'd3
  } phase_e;

  // Unescaped byte plus whether it came from an escape sequence.
  typedef struct packed {
    logic [7:0] data;
    logic       escaped;
  } fe_item_t;

  typedef struct packed {
    logic [7:0]  body_byte;
    logic [15:0] body_index;
    logic        is_last;
    logic [1:0]  frame_kind;
  } body_item_t;

  function automatic logic [1:0] kind_of(input logic [7:0] t);
    logic [1:0] k;
    if (t == TypeRx) k = KindRx;
    else if (t == TypeIo) k = KindIo;
    else if (t == TypeAt) k = KindAt;
    else k = KindUnknown;
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: design/eldf_front.sv
// Front part: accepts raw bytes and strips escape marks.
// Depends on eldf_pkg; feeds eldf_queue.
`timescale 1ns / 1ps
`default_nettype none

module eldf_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire logic [7:0]        rx_byte_i,
  output logic                   full_o,
  output logic                   q_push_o,
  output eldf_pkg::fe_item_t     q_item_o,
  input  wire logic              q_full_i
);

  logic accept;
  logic esc_pending_q, esc_pending_d;

  assign full_o = q_full_i;
  assign accept = push_i && !q_full_i;

  always_comb begin
    esc_pending_d    = esc_pending_q;
    q_push_o         = 1'b0;
    q_item_o.data    = rx_byte_i;
    q_item_o.escaped = 1'b0;
    if (accept) begin
      if (esc_pending_q) begin
        esc_pending_d    = 1'b0;
        q_item_o.data    = rx_byte_i ^ eldf_pkg::EscXor;
        q_item_o.escaped = 1'b1;
        q_push_o         = 1'b1;
      end else if (rx_byte_i == eldf_pkg::EscMark) begin
        // escape mark itself produces nothing
        esc_pending_d = 1'b1;
      end else begin
        q_push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_pending_q <= 1'b0;
    end else begin
      esc_pending_q <= esc_pending_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/eldf_queue.sv
// Short queue of unescaped bytes between the front and back parts.
// Depends on eldf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module eldf_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire eldf_pkg::fe_item_t wdata_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output eldf_pkg::fe_item_t      rdata_o,
  output logic                    empty_o
);

  eldf_pkg::fe_item_t mem_q [eldf_pkg::QueueDepth];
  logic [eldf_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [eldf_pkg::QueueCntW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == eldf_pkg::QueueCntW'(eldf_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + eldf_pkg::QueuePtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + eldf_pkg::QueuePtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + eldf_pkg::QueueCntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - eldf_pkg::QueueCntW'(1);
    end
  end

endmodule

`default_nettype wire

FILE: design/eldf_back.sv
// Back part: frame state machine and result queue.
// Depends on eldf_pkg; drains eldf_queue.
`timescale 1ns / 1ps
`default_nettype none

module eldf_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_empty_i,
  input  wire eldf_pkg::fe_item_t q_item_i,
  output logic                    q_pop_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output eldf_pkg::body_item_t    result_o
);

  eldf_pkg::phase_e phase_q, phase_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] len_q, len_d;
  logic [15:0] pos_q, pos_d;
  logic [1:0]  kind_q, kind_d;
  logic        emit;
  logic        last;
  logic [1:0]  kind_cur;
  eldf_pkg::body_item_t res;

  eldf_pkg::body_item_t out_mem_q [eldf_pkg::OutDepth];
  logic [eldf_pkg::OutPtrW-1:0] out_wr_q, out_rd_q;
  logic [eldf_pkg::OutCntW-1:0] out_cnt_q;
  logic out_full, out_pop;

  assign out_full = (out_cnt_q == eldf_pkg::OutCntW'(eldf_pkg::OutDepth));
  assign empty_o  = (out_cnt_q == '0);
  assign out_pop  = pop_i && !empty_o;
  assign q_pop_o  = !q_empty_i && !out_full;
  assign result_o = out_mem_q[out_rd_q];

  assign last     = (pos_q == len_q);
  assign kind_cur = (pos_q == '0) ? eldf_pkg::kind_of(q_item_i.data) : kind_q;

  always_comb begin
    phase_d  = phase_q;
    len_hi_d = len_hi_q;
    len_d    = len_q;
    pos_d    = pos_q;
    kind_d   = kind_q;
    emit     = 1'b0;
    res.body_byte  = q_item_i.data;
    res.body_index = pos_q;
    res.is_last    = last;
    res.frame_kind = kind_cur;
    if (q_pop_o) begin
      case (phase_q)
        eldf_pkg::PH_HUNT: begin
          // only a raw start mark opens a frame
          if (!q_item_i.escaped && q_item_i.data == eldf_pkg::StartMark) begin
            phase_d = eldf_pkg::PH_LENH;
          end
        end
        eldf_pkg::PH_LENH: begin
          len_hi_d = q_item_i.data;
          phase_d  = eldf_pkg::PH_LENL;
        end
        eldf_pkg::PH_LENL: begin
          len_d   = {len_hi_q, q_item_i.data};
          pos_d   = '0;
          phase_d = eldf_pkg::PH_BODY;
        end
        eldf_pkg::PH_BODY: begin
          emit   = 1'b1;
          kind_d = kind_cur;
          if (last) begin
            phase_d = eldf_pkg::PH_HUNT;
            pos_d   = '0;
          end else begin
            pos_d = pos_q + 16'd1;
          end
        end
        default: begin
          phase_d = eldf_pkg::PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= eldf_pkg::PH_HUNT;
      len_hi_q <= '0;
      len_q    <= '0;
      pos_q    <= '0;
      kind_q   <= eldf_pkg::KindRx;
    end else begin
      phase_q  <= phase_d;
      len_hi_q <= len_hi_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      kind_q   <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_mem_q[out_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      if (emit)    out_wr_q <= out_wr_q + eldf_pkg::OutPtrW'(1);
      if (out_pop) out_rd_q <= out_rd_q + eldf_pkg::OutPtrW'(1);
      if (emit && !out_pop)      out_cnt_q <= out_cnt_q + eldf_pkg::OutCntW'(1);
      else if (out_pop && !emit) out_cnt_q <= out_cnt_q - eldf_pkg::OutCntW'(1);
    end
  end

endmodule

`default_nettype wire

FILE: design/escaped_length_frame_deframer_top.sv
// Escaped length frame deframer, top level.
// Raw serial bytes are pushed in through push/full; each is accepted at a
// clock edge with push high and full low. Escape marks are removed and the
// next byte unescaped. Bytes outside a frame are dropped; a raw 0x7E opens a
// frame, two length bytes follow, then length+1 body bytes come out as items.
// Results are read through empty/pop: while empty is low the oldest item is
// on body_byte_o, body_index_o, is_last_o and frame_kind_o, and it leaves at
// an edge with pop high. An accepted body byte is registered in the middle
// queue, then goes through the frame state machine into the result queue,
// whose head drives the result ports. Throughput is one byte per cycle
// while the result queue is not full, set by the one-byte-per-cycle state
// update in the back part. When the reader stalls, the two-entry result queue
// fills, then the four-entry middle queue, then full rises. Reset empties
// both queues, clears a pending escape and returns to hunting for 0x7E.
// Depends on eldf_pkg, eldf_front, eldf_queue, eldf_back.
`timescale 1ns / 1ps
`default_nettype none

module escaped_length_frame_deframer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  input  wire logic [7:0]  rx_byte_i,
  output logic             full,
  input  wire logic        pop,
  output logic             empty,
  output logic [7:0]       body_byte_o,
  output logic [15:0]      body_index_o,
  output logic             is_last_o,
  output logic [1:0]       frame_kind_o
);

  logic                 q_push, q_full, q_pop, q_empty;
  eldf_pkg::fe_item_t   q_wdata, q_rdata;
  eldf_pkg::body_item_t result;

  eldf_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .rx_byte_i (rx_byte_i),
    .full_o    (full),
    .q_push_o  (q_push),
    .q_item_o  (q_wdata),
    .q_full_i  (q_full)
  );

  eldf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  eldf_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_item_i  (q_rdata),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .result_o  (result)
  );

  assign body_byte_o  = result.body_byte;
  assign body_index_o = result.body_index;
  assign is_last_o    = result.is_last;
  assign frame_kind_o = result.frame_kind;

endmodule

`default_nettype wire

FILE: design/eldf_checker.sv
// Port-level checker for the deframer, bound to the top level.
// Depends on eldf_pkg and escaped_length_frame_deframer_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "escaped_length_frame_deframer_top_defines.svh"

module eldf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pop,
  input wire logic        empty,
  input wire logic [7:0]  body_byte_o,
  input wire logic [15:0] body_index_o,
  input wire logic        is_last_o,
  input wire logic [1:0]  frame_kind_o
);

  logic        out_acc;
  logic        prev_valid_q;
  logic        prev_last_q;
  logic [15:0] prev_index_q;
  logic [1:0]  prev_kind_q;

  assign out_acc = pop && !empty;

  // remember the last item taken from the result side
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_valid_q <= 1'b0;
      prev_last_q  <= 1'b0;
      prev_index_q <= '0;
      prev_kind_q  <= '0;
    end else if (out_acc) begin
      prev_valid_q <= 1'b1;
      prev_last_q  <= is_last_o;
      prev_index_q <= body_index_o;
      prev_kind_q  <= frame_kind_o;
    end
  end

  `ELDF_ASSERT_NEXT(a_hold_stalled, !empty && !pop, !empty && $stable(body_byte_o) && $stable(body_index_o) && $stable(is_last_o) && $stable(frame_kind_o), "stalled item changed")
  `ELDF_ASSERT_NOW(a_index_step, out_acc && prev_valid_q && !prev_last_q, body_index_o == prev_index_q + 16'd1 && frame_kind_o == prev_kind_q, "body item out of sequence")
  `ELDF_ASSERT_NOW(a_frame_start, out_acc && (!prev_valid_q || prev_last_q), body_index_o == 16'd0, "frame does not start at index zero")
  `ELDF_ASSERT_NOW(a_kind_decode, !empty && body_index_o == 16'd0, frame_kind_o == eldf_pkg::kind_of(body_byte_o), "frame kind does not match type byte")

endmodule

bind escaped_length_frame_deframer_top eldf_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .pop          (pop),
  .empty        (empty),
  .body_byte_o  (body_byte_o),
  .body_index_o (body_index_o),
  .is_last_o    (is_last_o),
  .frame_kind_o (frame_kind_o)
);

`default_nettype wire
